// ===== sv/mrfm_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mrfm_pkg
// Shared types and constants of the mains RMS and frequency meter.
// ============================================================================
package mrfm_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGE_MIN_GAP = 3'd0,
        REG_WINDOW_MIN   = 3'd1,
        REG_WINDOW_MAX   = 3'd2,
        REG_TIMEOUT      = 3'd3,
        REG_VOLT_GAIN    = 3'd4,
        REG_BASE_PERIOD  = 3'd5
    } reg_idx_t;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_EDGE = 1'b1
    } cmd_t;

    localparam logic [15:0] RST_EDGE_MIN_GAP = 16'd2000;
    localparam logic [5:0]  RST_WINDOW_MIN   = 6'd13;
    localparam logic [5:0]  RST_WINDOW_MAX   = 6'd33;
    localparam logic [7:0]  RST_TIMEOUT      = 8'd66;
    localparam logic [15:0] RST_VOLT_GAIN    = 16'd20953;
    localparam logic [15:0] RST_BASE_PERIOD  = 16'd1000;
    localparam int unsigned RESET_WINDOW     = 20;

    localparam logic [11:0] MV_FULL   = 12'd3300;
    localparam logic [11:0] ADC_FULL  = 12'd4095;
    localparam logic [31:0] FREQ_NUM  = 32'd10000000;
    localparam logic [18:0] RMS_SAT   = 19'd524287;
    localparam logic [9:0]  FREQ_SAT  = 10'd1023;

    // 2^37 / 100 rounded up: (x * RECIP_100) >> 37 equals x / 100 for any
    // 32-bit x.
    localparam logic [31:0] RECIP_100 = 32'h51EB_851F;

    // One queued item passed from the front to the back.
    typedef struct packed {
        cmd_t        command;
        logic [11:0] adc_raw;
        logic [31:0] edge_time_us;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EDGE, ST_SCALE, ST_RDOLD, ST_SUB, ST_ADD, ST_DIV,
        ST_SQRT, ST_PDIV, ST_DECIDE, ST_FDIV, ST_GAIN, ST_OUT
    } st_t;

endpackage

// ===== sv/mrfm_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mrfm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module mrfm_ram #(
    parameter int unsigned WIDTH = 12,
    parameter int unsigned DEPTH = 33
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

// ===== sv/mrfm_divu.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mrfm_divu
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ============================================================================
module mrfm_divu (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = '0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            trial = {rem_reg[31:0], quo_reg[31]};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = busy_reg && (cnt_reg == 6'd1);
    assign quotient = {quo_reg[30:0], (trial >= {1'b0, dvs_reg})};
endmodule

// ===== sv/mrfm_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mrfm_front
// Input side: accepts items into a two-entry queue toward the back end.
// ============================================================================
module mrfm_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mrfm_pkg::item_t in_item,
    output logic            q_valid,
    input  logic            q_pop,
    output mrfm_pkg::item_t q_item
);
    import mrfm_pkg::*;

    item_t       slot_reg [2];
    logic        wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ q_pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            slot_reg[wp_reg] <= in_item;
        end
    end
endmodule

// ===== sv/mrfm_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mrfm_back
// Execution side: edge bookkeeping, sliding window, root and scaling.
// ============================================================================
module mrfm_back #(
    parameter int unsigned WINDOW_DEPTH = 33
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_pop,
    input  mrfm_pkg::item_t q_item,
    input  logic [15:0]     edge_min_gap_us,
    input  logic [5:0]      window_min,
    input  logic [5:0]      window_max,
    input  logic [7:0]      timeout_ticks,
    input  logic [15:0]     volt_gain,
    input  logic [15:0]     base_period_us,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [18:0]     m_vin_rms_mv,
    output logic [9:0]      m_freq_dhz,
    output logic            m_ac_present
);
    import mrfm_pkg::*;

    localparam int unsigned AW = $clog2(WINDOW_DEPTH);
    localparam logic [5:0] RST_LEN =
        6'((RESET_WINDOW < WINDOW_DEPTH) ? RESET_WINDOW : WINDOW_DEPTH);
    localparam logic [6:0] DEPTH7 = 7'(WINDOW_DEPTH);

    st_t         st_reg, st_next;
    item_t       it_reg, it_next;
    logic [31:0] last_reg, last_next, prev_reg, prev_next, per_reg, per_next;
    logic        seen_reg, seen_next;
    logic [7:0]  twe_reg, twe_next;
    logic [5:0]  head_reg, head_next, fill_reg, fill_next, len_reg, len_next;
    logic [16:0] sum_reg, sum_next;
    logic [28:0] sq_reg, sq_next;
    logic [18:0] rms_reg, rms_next;
    logic [9:0]  freq_reg, freq_next;
    logic        pres_reg, pres_next;
    logic        mval_reg, mval_next;
    logic [11:0] mv_reg, mv_next;
    logic        full_reg, full_next;
    logic [11:0] mean_reg, mean_next;
    logic [31:0] sv_reg, sv_next, root_reg, root_next, bit_reg, bit_next;
    logic [15:0] rmsv_reg, rmsv_next;
    logic [31:0] n_reg, n_next;
    logic [1:0]  dph_reg, dph_next;
    logic [31:0] gprod_reg, gprod_next;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [11:0] rdata;
    logic        dstart, ddone;
    logic [31:0] ddend, ddvs, dquo;
    logic [23:0] mvprod;
    logic [23:0] mm;
    logic [63:0] gq;
    logic        nok;

    mrfm_ram #(.WIDTH(12), .DEPTH(WINDOW_DEPTH)) u_ring (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(mv_reg),
        .raddr(raddr), .rdata(rdata)
    );

    mrfm_divu u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart), .dividend(ddend),
        .divisor(ddvs), .done(ddone), .quotient(dquo)
    );

    always_comb begin
        st_next = st_reg; it_next = it_reg;
        last_next = last_reg; prev_next = prev_reg; per_next = per_reg;
        seen_next = seen_reg; twe_next = twe_reg;
        head_next = head_reg; fill_next = fill_reg; len_next = len_reg;
        sum_next = sum_reg; sq_next = sq_reg;
        rms_next = rms_reg; freq_next = freq_reg; pres_next = pres_reg;
        mval_next = mval_reg; mv_next = mv_reg; full_next = full_reg;
        mean_next = mean_reg; sv_next = sv_reg;
        root_next = root_reg; bit_next = bit_reg; rmsv_next = rmsv_reg;
        n_next = n_reg; dph_next = dph_reg; gprod_next = gprod_reg;
        q_pop = 1'b0; we = 1'b0; dstart = 1'b0; ddend = '0; ddvs = 32'd1;
        mvprod = '0; mm = '0; gq = '0; nok = 1'b0;
        waddr = AW'(({1'b0, head_reg} >= DEPTH7) ? 7'd0 : {1'b0, head_reg});
        raddr = waddr;
        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end
        unique case (st_reg)
            ST_IDLE: begin
                if (q_valid && !mval_reg) begin
                    q_pop = 1'b1;
                    it_next = q_item;
                    st_next = (q_item.command == CMD_EDGE) ? ST_EDGE : ST_SCALE;
                end
            end
            ST_EDGE: begin
                if ((it_reg.edge_time_us - last_reg) >= {16'd0, edge_min_gap_us}) begin
                    per_next  = it_reg.edge_time_us - prev_reg;
                    prev_next = last_reg;
                    last_next = it_reg.edge_time_us;
                    seen_next = 1'b1;
                end
                st_next = ST_OUT;
            end
            ST_SCALE: begin
                if (seen_reg) begin
                    seen_next = 1'b0;
                    twe_next = '0;
                end else if (twe_reg != 8'd255) begin
                    twe_next = twe_reg + 8'd1;
                end
                mvprod = it_reg.adc_raw * MV_FULL;
                // Divide by 4095 with one word shift: x/4095 ~ (x + x/4096 + 1)/4096.
                mv_next = 12'((mvprod + (mvprod >> 12) + 24'd1) >> 12);
                st_next = ST_RDOLD;
            end
            ST_RDOLD: begin
                // RAM read of the slot being overwritten is in flight.
                st_next = ST_SUB;
            end
            ST_SUB: begin
                if (fill_reg >= len_reg) begin
                    sum_next = sum_reg - {5'd0, rdata};
                    sq_next  = sq_reg - {5'd0, {12'd0, rdata} * {12'd0, rdata}};
                end else begin
                    fill_next = fill_reg + 6'd1;
                end
                st_next = ST_ADD;
            end
            ST_ADD: begin
                we = 1'b1;
                head_next = (({1'b0, waddr} + 7'd1) >= {1'b0, len_reg}) ? 6'd0
                          : 6'(waddr + 1'b1);
                sum_next = sum_reg + {5'd0, mv_reg};
                sq_next  = sq_reg + {5'd0, {12'd0, mv_reg} * {12'd0, mv_reg}};
                full_next = (fill_reg >= len_reg);
                dph_next = 2'd0;
                st_next = ST_DIV;
            end
            ST_DIV: begin
                // Mean then mean square, both by the window length.
                if (dph_reg == 2'd0) begin
                    dstart = 1'b1; ddend = {15'd0, sum_reg}; ddvs = {26'd0, len_reg};
                    dph_next = 2'd1;
                end else if (dph_reg == 2'd1) begin
                    if (ddone) begin
                        // The mean never exceeds the 3300 mV full scale.
                        mean_next = dquo[11:0];
                        dph_next = 2'd2;
                    end
                end else if (dph_reg == 2'd2) begin
                    dstart = 1'b1; ddend = {3'd0, sq_reg}; ddvs = {26'd0, len_reg};
                    dph_next = 2'd3;
                end else begin
                    if (ddone) begin
                        mm = mean_reg * mean_reg;
                        root_next = '0;
                        bit_next = 32'h4000_0000;
                        if (!full_reg || (dquo < {8'd0, mm})) begin
                            sv_next = '0;
                        end else begin
                            sv_next = dquo - {8'd0, mm};
                        end
                        st_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                // Sixteen bit-pair steps; pairs above the operand leave the
                // root at zero, so no separate search for the top pair.
                if (bit_reg == 32'd0) begin
                    rmsv_next = 16'(root_reg);
                    st_next = ST_PDIV;
                    dph_next = 2'd0;
                end else begin
                    if (sv_reg >= root_reg + bit_reg) begin
                        sv_next = sv_reg - (root_reg + bit_reg);
                        root_next = (root_reg >> 1) + bit_reg;
                    end else begin
                        root_next = root_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            ST_PDIV: begin
                if (dph_reg == 2'd0) begin
                    dstart = 1'b1; ddend = per_reg; ddvs = {16'd0, base_period_us};
                    dph_next = 2'd1;
                    if (base_period_us == 16'd0) begin
                        dstart = 1'b0;
                        n_next = '0;
                        st_next = ST_DECIDE;
                    end
                end else if (ddone) begin
                    n_next = dquo;
                    st_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                nok = (n_reg != 32'd0) && (n_reg >= {26'd0, window_min})
                   && (n_reg <= {26'd0, window_max}) && (n_reg <= {25'd0, DEPTH7});
                if (!nok || (twe_reg > timeout_ticks)) begin
                    pres_next = 1'b0; freq_next = '0; rms_next = '0;
                    st_next = ST_OUT;
                end else if (n_reg[5:0] != len_reg) begin
                    head_next = '0; fill_next = '0; sum_next = '0; sq_next = '0;
                    len_next = n_reg[5:0]; rms_next = '0;
                    st_next = ST_OUT;
                end else begin
                    dph_next = 2'd0;
                    st_next = ST_FDIV;
                end
            end
            ST_FDIV: begin
                if (dph_reg == 2'd0) begin
                    dstart = 1'b1; ddend = FREQ_NUM; ddvs = per_reg;
                    dph_next = 2'd1;
                end else if (ddone) begin
                    freq_next = (dquo > {22'd0, FREQ_SAT}) ? FREQ_SAT : dquo[9:0];
                    pres_next = 1'b1;
                    gprod_next = rmsv_reg * volt_gain;
                    dph_next = 2'd0;
                    st_next = (rmsv_reg != 16'd0) ? ST_GAIN : ST_OUT;
                end
            end
            ST_GAIN: begin
                // Division by 100 as a multiplication by its reciprocal.
                gq = {32'd0, gprod_reg} * {32'd0, RECIP_100};
                rms_next = (gq[63:37] > {8'd0, RMS_SAT}) ? RMS_SAT : gq[55:37];
                st_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mval_reg) begin
                    mval_next = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            last_reg <= '0; prev_reg <= '0; per_reg <= '0;
            seen_reg <= 1'b0; twe_reg <= '0;
            head_reg <= '0; fill_reg <= '0; len_reg <= RST_LEN;
            sum_reg <= '0; sq_reg <= '0;
            rms_reg <= '0; freq_reg <= '0; pres_reg <= 1'b0;
            mval_reg <= 1'b0; dph_reg <= '0;
        end else begin
            st_reg <= st_next;
            last_reg <= last_next; prev_reg <= prev_next; per_reg <= per_next;
            seen_reg <= seen_next; twe_reg <= twe_next;
            head_reg <= head_next; fill_reg <= fill_next; len_reg <= len_next;
            sum_reg <= sum_next; sq_reg <= sq_next;
            rms_reg <= rms_next; freq_reg <= freq_next; pres_reg <= pres_next;
            mval_reg <= mval_next; dph_reg <= dph_next;
        end
        it_reg <= it_next; mv_reg <= mv_next; full_reg <= full_next;
        mean_reg <= mean_next; sv_reg <= sv_next;
        root_reg <= root_next; bit_reg <= bit_next; rmsv_reg <= rmsv_next;
        n_reg <= n_next; gprod_reg <= gprod_next;
    end

    assign m_valid      = mval_reg;
    assign m_vin_rms_mv = rms_reg;
    assign m_freq_dhz   = freq_reg;
    assign m_ac_present = pres_reg;
endmodule

// ===== sv/mains_rms_frequency_meter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mains_rms_frequency_meter
// Sliding-window true RMS and mains frequency meter.
// ============================================================================
// Every item, tick or edge, produces exactly one result item holding the
// published RMS voltage, frequency and presence flag. A tick item's run
// time is set by the one shared radix-2 divider (mean, mean square,
// period by base period and frequency), the 16-step bit-pair square
// root, and whether the reading is refused early. The gain's division
// by 100 is a single reciprocal multiplication.
// Two items may wait in the input queue while the back end works, and a
// finished result waits in its output register until it is taken.
module mains_rms_frequency_meter #(
    parameter int unsigned WINDOW_DEPTH = 33
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [11:0] s_adc_raw,
    input  logic [31:0] s_edge_time_us,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [18:0] m_vin_rms_mv,
    output logic [9:0]  m_freq_dhz,
    output logic        m_ac_present,
    input  logic        cfg_we,
    input  logic [mrfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrfm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mrfm_pkg::*;

    logic [15:0] gap_reg, gain_reg, base_reg;
    logic [5:0]  wmin_reg, wmax_reg;
    logic [7:0]  tmo_reg;
    item_t       in_item, q_item;
    logic        q_valid, q_pop;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg <= RST_EDGE_MIN_GAP; wmin_reg <= RST_WINDOW_MIN;
            wmax_reg <= RST_WINDOW_MAX; tmo_reg <= RST_TIMEOUT;
            gain_reg <= RST_VOLT_GAIN; base_reg <= RST_BASE_PERIOD;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_EDGE_MIN_GAP: gap_reg  <= cfg_data;
                REG_WINDOW_MIN:   wmin_reg <= cfg_data[5:0];
                REG_WINDOW_MAX:   wmax_reg <= cfg_data[5:0];
                REG_TIMEOUT:      tmo_reg  <= cfg_data[7:0];
                REG_VOLT_GAIN:    gain_reg <= cfg_data;
                REG_BASE_PERIOD:  base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item.command      = cmd_t'(s_command);
    assign in_item.adc_raw      = s_adc_raw;
    assign in_item.edge_time_us = s_edge_time_us;

    mrfm_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
    );

    mrfm_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_pop(q_pop),
        .q_item(q_item), .edge_min_gap_us(gap_reg), .window_min(wmin_reg),
        .window_max(wmax_reg), .timeout_ticks(tmo_reg), .volt_gain(gain_reg),
        .base_period_us(base_reg), .m_valid(m_valid), .m_ready(m_ready),
        .m_vin_rms_mv(m_vin_rms_mv), .m_freq_dhz(m_freq_dhz),
        .m_ac_present(m_ac_present)
    );

`ifndef SYNTH
    // Absent mains always publishes zero frequency.
    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ac_present |-> m_freq_dhz == '0)
        else $error("frequency nonzero while absent");
    // A waiting result is not replaced before it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vin_rms_mv))
        else $error("result changed while stalled");
`endif
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the mains RMS and frequency meter.
// ============================================================================
// Sample ticks and zero-crossing edges are sent over the input channel, and
// every reading that comes back is compared with one worked out by a
// predictor kept in this file. Directed items cover the field extremes, edge
// jitter, timestamp wrap and timeouts. Configuration sweeps then cover the
// register extremes. Random mains waveforms follow, with random periods,
// window limits, gains and jitter edges. Both channel sides stall in random
// bursts, except in the final stretch of the run.
// ============================================================================
module tb_top;
    import mrfm_pkg::*;

    localparam int unsigned DEPTH = 33;
    localparam int unsigned IDLE_LIMIT = 5000;
    localparam int unsigned END_WAIT = 400;
    localparam int unsigned ITEM_TARGET = 1800;
    localparam int unsigned QUIET_ITEMS = 200;
    // No register lives at this index; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct {
        logic [18:0] rms_mv;
        logic [9:0]  freq_dhz;
        logic        present;
    } reading_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_command;
    logic [11:0] s_adc_raw;
    logic [31:0] s_edge_time_us;
    logic        m_valid;
    logic        m_ready;
    logic [18:0] m_vin_rms_mv;
    logic [9:0]  m_freq_dhz;
    logic        m_ac_present;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mains_rms_frequency_meter #(.WINDOW_DEPTH(DEPTH)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_adc_raw      (s_adc_raw),
        .s_edge_time_us (s_edge_time_us),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_vin_rms_mv   (m_vin_rms_mv),
        .m_freq_dhz     (m_freq_dhz),
        .m_ac_present   (m_ac_present),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the registers and of the meter.
    // ------------------------------------------------------------------
    logic [15:0] min_gap_us;
    logic [5:0]  win_min;
    logic [5:0]  win_max;
    logic [7:0]  timeout_lim;
    logic [15:0] gain;
    logic [15:0] base_us;

    logic [31:0] edge_recent_us;
    logic [31:0] prev_edge;
    logic [31:0] cycle_us;
    logic        edge_flag;
    logic [7:0]  idle_ticks;
    logic [11:0] ring_mv [DEPTH];
    logic [5:0]  head;
    logic [5:0]  fill;
    logic [5:0]  wlen;
    logic [31:0] acc_sum;
    logic [31:0] acc_sq;
    logic [18:0] rms_pub;
    logic [9:0]  freq_pub;
    logic        present_pub;

    reading_t readings_due[$];

    int unsigned errors;
    int unsigned items_sent;
    int unsigned readings_seen;
    int unsigned present_seen;
    int unsigned idle_cycles;
    bit          quiet;
    logic [31:0] edge_clock;

    // ------------------------------------------------------------------
    // Clock, and the watchdog that ends a run which stops moving.
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Integer square root, bit-pair method, rounding down.
    function automatic logic [31:0] root_floor(input logic [31:0] v);
        logic [31:0] root;
        logic [31:0] bitv;
        root = 0;
        bitv = 32'h4000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    task automatic clear_window(input logic [5:0] n);
        head = 0;
        fill = 0;
        acc_sum = 0;
        acc_sq = 0;
        wlen = n;
    endtask

    task automatic meter_reset();
        min_gap_us = RST_EDGE_MIN_GAP;
        win_min = RST_WINDOW_MIN;
        win_max = RST_WINDOW_MAX;
        timeout_lim = RST_TIMEOUT;
        gain = RST_VOLT_GAIN;
        base_us = RST_BASE_PERIOD;
        edge_recent_us = 0;
        prev_edge = 0;
        cycle_us = 0;
        edge_flag = 1'b0;
        idle_ticks = 0;
        clear_window(6'((RESET_WINDOW < DEPTH) ? RESET_WINDOW : DEPTH));
        rms_pub = 0;
        freq_pub = 0;
        present_pub = 1'b0;
    endtask

    // Slides one sample into the window and returns the window's AC RMS,
    // or zero while the window is still filling.
    function automatic logic [31:0] window_rms(input logic [31:0] mv);
        logic [31:0] h;
        logic [31:0] old;
        logic [31:0] mean;
        logic [31:0] msq;
        h = head;
        if (h >= DEPTH) h = 0;
        if (fill >= wlen) begin
            old = ring_mv[h[5:0]];
            acc_sum = acc_sum - old;
            acc_sq = acc_sq - old * old;
        end else begin
            fill = fill + 6'd1;
        end
        ring_mv[h[5:0]] = mv[11:0];
        head = 6'((h + 1) % wlen);
        acc_sum = acc_sum + mv;
        acc_sq = acc_sq + mv * mv;
        if (fill < wlen) return 0;
        mean = acc_sum / wlen;
        msq = acc_sq / wlen;
        if (msq < mean * mean) return 0;
        return root_floor(msq - mean * mean);
    endfunction

    // Window length that the measured period asks for, zero if refused.
    function automatic logic [31:0] period_len();
        logic [31:0] n;
        if (base_us == 0) return 0;
        n = cycle_us / base_us;
        if (n < 1 || n < win_min || n > win_max || n > DEPTH) return 0;
        return n;
    endfunction

    // Works out the reading that one accepted item must produce.
    task automatic meter_step(input cmd_t cmd, input logic [11:0] adc,
                              input logic [31:0] t_us, output reading_t r);
        logic [31:0] rms;
        logic [31:0] n;
        logic [31:0] f;
        logic [63:0] scaled;
        if (cmd == CMD_EDGE) begin
            // Same-slope period: from the edge before last to this one.
            if (t_us - edge_recent_us >= min_gap_us) begin
                cycle_us = t_us - prev_edge;
                prev_edge = edge_recent_us;
                edge_recent_us = t_us;
                edge_flag = 1'b1;
            end
        end else begin
            if (edge_flag) begin
                edge_flag = 1'b0;
                idle_ticks = 0;
            end else if (idle_ticks != 8'd255) begin
                idle_ticks = idle_ticks + 8'd1;
            end
            rms = window_rms(32'(adc) * MV_FULL / ADC_FULL);
            n = period_len();
            if (n == 0 || idle_ticks > timeout_lim) begin
                present_pub = 1'b0;
                freq_pub = 0;
                rms_pub = 0;
            end else if (n != wlen) begin
                clear_window(n[5:0]);
                rms_pub = 0;
            end else begin
                f = FREQ_NUM / cycle_us;
                freq_pub = (f > FREQ_SAT) ? FREQ_SAT : f[9:0];
                if (rms != 0) begin
                    scaled = 64'(rms) * gain / 100;
                    rms_pub = (scaled > RMS_SAT) ? RMS_SAT : scaled[18:0];
                end
                present_pub = 1'b1;
            end
        end
        r.rms_mv = rms_pub;
        r.freq_dhz = freq_pub;
        r.present = present_pub;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, and the comparison of every reading.
    // ------------------------------------------------------------------
    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    initial begin
        m_ready = 1'b1;
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            readings_seen++;
            if (m_ac_present) present_seen++;
            if (readings_due.size() == 0) begin
                report("reading with none pending, rms", m_vin_rms_mv, 0);
            end else begin
                want = readings_due.pop_front();
                if (m_vin_rms_mv !== want.rms_mv)
                    report("vin_rms_mv", m_vin_rms_mv, want.rms_mv);
                if (m_freq_dhz !== want.freq_dhz)
                    report("freq_dhz", m_freq_dhz, want.freq_dhz);
                if (m_ac_present !== want.present)
                    report("ac_present", m_ac_present, want.present);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------
    // Holds one item on the channel until it is taken, then predicts its
    // reading. Valid is left high so that a following item goes out in
    // the next cycle; a random gap lowers it.
    task automatic send_item(input cmd_t cmd, input logic [11:0] adc,
                             input logic [31:0] t_us);
        reading_t r;
        s_valid <= 1'b1;
        s_command <= cmd;
        s_adc_raw <= adc;
        s_edge_time_us <= t_us;
        do @(posedge aclk); while (!s_ready);
        meter_step(cmd, adc, t_us, r);
        readings_due.push_back(r);
        items_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    task automatic tick(input logic [11:0] adc);
        send_item(CMD_TICK, adc, $urandom);
    endtask

    task automatic edge_at(input logic [31:0] t_us);
        send_item(CMD_EDGE, 12'($urandom), t_us);
    endtask

    // Lets every pending reading arrive; the meter is then idle, since
    // each item yields exactly one reading.
    task automatic drain();
        s_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_EDGE_MIN_GAP: min_gap_us = value;
            REG_WINDOW_MIN:   win_min = value[5:0];
            REG_WINDOW_MAX:   win_max = value[5:0];
            REG_TIMEOUT:      timeout_lim = value[7:0];
            REG_VOLT_GAIN:    gain = value;
            REG_BASE_PERIOD:  base_us = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] gap, input logic [5:0] wmin,
                             input logic [5:0] wmax, input logic [7:0] tmo,
                             input logic [15:0] vg, input logic [15:0] base);
        drain();
        write_reg(REG_EDGE_MIN_GAP, gap);
        write_reg(REG_WINDOW_MIN, {10'd0, wmin});
        write_reg(REG_WINDOW_MAX, {10'd0, wmax});
        write_reg(REG_TIMEOUT, {8'd0, tmo});
        write_reg(REG_VOLT_GAIN, vg);
        write_reg(REG_BASE_PERIOD, base);
    endtask

    // A run of mains half cycles: one edge per half cycle, then a handful
    // of ticks around mid-scale. Now and then a jitter edge follows right
    // after the real one and must be dropped.
    task automatic mains_run(input int halves, input logic [31:0] half_us,
                             input int unsigned amp);
        int unsigned k;
        for (int i = 0; i < halves; i++) begin
            edge_clock = edge_clock + half_us + $urandom_range(0, 3);
            edge_at(edge_clock);
            if (min_gap_us > 1 && $urandom_range(0, 11) == 0)
                edge_at(edge_clock + $urandom_range(1, min_gap_us - 1));
            k = $urandom_range(2, 14);
            repeat (k) tick(12'(2048 + $urandom_range(0, 2 * amp) - amp));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    // Field extremes at the reset settings, jitter and timestamp wrap.
    task automatic test_directed();
        tick(12'd0);
        tick(12'd4095);
        edge_at(32'd0);            // too close to the reset timestamp
        edge_at(32'hFFFF_FFFF);    // far away once the difference wraps
        edge_at(32'd1000);         // wraps to a gap below the minimum
        edge_at(32'd9999);
        tick(12'd4095);
        edge_at(32'd19999);
        tick(12'd0);
        tick(12'hAAA);
        tick(12'h555);
        edge_at(32'd29999);
        tick(12'd4095);
        edge_at(32'd29999);        // repeated timestamp: zero gap
        tick(12'd1);
        edge_clock = 32'd29999;
    endtask

    // Steady mains at reset settings until the window fills and publishes.
    task automatic test_steady_mains();
        mains_run(12, 32'd10000, 1500);
        drain();   // the sender waits here for every reading to arrive
    endtask

    // Timeout extremes: zero declares absence on any tick without an edge,
    // and 255 never times out.
    task automatic test_timeouts();
        configure(16'd2000, 6'd13, 6'd33, 8'd0, 16'd20953, 16'd1000);
        mains_run(6, 32'd10000, 800);
        configure(16'd2000, 6'd13, 6'd33, 8'd255, 16'd20953, 16'd1000);
        mains_run(4, 32'd10000, 800);
        repeat (270) tick(12'($urandom));
        configure(16'd2000, 6'd13, 6'd33, 8'd3, 16'd20953, 16'd1000);
        mains_run(4, 32'd10000, 800);
        repeat (6) tick(12'($urandom));
    endtask

    // Register extremes: gap limits, one-sample and full windows, reversed
    // limits, zero and saturating gain, base period extremes, and a write
    // to an index with no register.
    task automatic test_register_extremes();
        configure(16'd0, 6'd1, 6'd1, 8'd255, 16'd65535, 16'd1);
        mains_run(8, 32'd1, 2000);
        configure(16'd0, 6'd33, 6'd33, 8'd255, 16'd65535, 16'd1);
        mains_run(12, 32'd17, 2047);
        configure(16'd65535, 6'd1, 6'd33, 8'd100, 16'd0, 16'd1000);
        mains_run(10, 32'd70000, 1500);
        configure(16'd100, 6'd20, 6'd10, 8'd100, 16'd20953, 16'd1000);
        mains_run(6, 32'd7500, 1500);
        configure(16'd100, 6'd1, 6'd33, 8'd100, 16'd65535, 16'd1000);
        mains_run(14, 32'd2500, 2047);  // frequency above the output range
        configure(16'd1000, 6'd1, 6'd33, 8'd100, 16'd12345, 16'd65535);
        mains_run(6, 32'd98000, 1000);
        drain();
        write_reg(REG_NONE, 16'hFFFF);
        mains_run(6, 32'd98000, 1000);
        configure(16'd0, 6'd1, 6'd33, 8'd100, 16'd20953, 16'd0);
        mains_run(4, 32'd10000, 1000);
    endtask

    // Random settings and waveforms; periods sometimes change mid-run to
    // force a new window length. The last stretch runs without stalls.
    task automatic test_random_mains();
        logic [5:0]  wmin;
        logic [5:0]  wmax;
        logic [15:0] base;
        int unsigned n;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET - QUIET_ITEMS) quiet = 1'b1;
            if ($urandom_range(0, 2) == 0) begin
                wmin = 6'($urandom_range(1, 20));
                wmax = 6'($urandom_range(wmin, 33));
                base = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                   : 16'd1000;
                configure(16'($urandom_range(0, 4000)), wmin, wmax,
                          8'($urandom_range(8, 255)), 16'($urandom), base);
            end
            n = $urandom_range(1, 34);
            mains_run($urandom_range(3, 12), 32'(base_us) * n / 2 + 32'(base_us / 2),
                      $urandom_range(0, 2047));
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 40)) tick(12'($urandom));
        end
    endtask

    initial begin
        errors = 0;
        items_sent = 0;
        readings_seen = 0;
        present_seen = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        edge_clock = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = CMD_TICK;
        s_adc_raw = '0;
        s_edge_time_us = '0;
        cfg_we = 1'b0;
        cfg_index = REG_EDGE_MIN_GAP;
        cfg_data = '0;
        meter_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_steady_mains();
        test_timeouts();
        test_register_extremes();
        test_random_mains();

        s_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge aclk);
        repeat (END_WAIT) @(posedge aclk);

        $display("sent %0d items (ticks and edges) and checked %0d readings,",
                 items_sent, readings_seen);
        $display("%0d of them with mains present, over register extremes and random mains",
                 present_seen);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
